// ===== rtl/midi_stream_parser_with_sysex_top_macros.svh =====
// Assertion macros shared by the MIDI parser checker.
// Each macro names clk and rst_n of the module that uses it.
`ifndef MIDI_STREAM_PARSER_WITH_SYSEX_TOP_MACROS_SVH
`define MIDI_STREAM_PARSER_WITH_SYSEX_TOP_MACROS_SVH

// Same-cycle implication
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared constants for the MIDI stream parser: store sizing, status codes
// and result kinds.
// ----------------------------------------------------------------------------
package msp_pkg;

  // SysEx payload store
  localparam int SYSEX_DEPTH = 32;
  localparam int SYSEX_AW    = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
  localparam int FILL_W      = $clog2(SYSEX_DEPTH + 1);

  // Status byte codes
  localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
  localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
  localparam logic [3:0] ST_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] ST_SYSTEM       = 4'hF;

  // Result kinds
  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_SYSEX   = 1'b1;

  localparam logic [15:0] OVF_MAX = 16'hFFFF;

endpackage

// ===== rtl/midi_stream_parser_with_sysex_top.sv =====
// A channel message appears on the outputs in the cycle after its last byte is taken. On F7
// a SysEx flush starts: each byte comes from the single registered read port of the payload
// RAM, which paces the flush, then passes the output register, one byte per cycle while the
// output is not stalled. One input byte per cycle while idle with the output register free.
// Reset (rst_n low, synchronous) clears all parser state and the output valid flag;
// the payload RAM keeps its contents and gets no clearing pass.
// ----------------------------------------------------------------------------
// midi_stream_parser_with_sysex_top
// MIDI byte parser: running-status channel messages plus buffered SysEx
// payload, flushed from RAM on F7 unless it overflowed or is empty.
// ----------------------------------------------------------------------------
module midi_stream_parser_with_sysex_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_status_byte,
  output logic [6:0]  out_first_data,
  output logic [6:0]  out_second_data,
  output logic [6:0]  out_sysex_data,
  output logic [5:0]  out_sysex_length,
  output logic        out_last_of_run,
  output logic [15:0] out_overflow_count
);

  localparam int AW = msp_pkg::SYSEX_AW;
  localparam int FW = msp_pkg::FILL_W;

  typedef enum logic {S_IDLE, S_FLUSH} state_t;

  state_t         state_r, state_nxt;
  logic [7:0]     rs_r, rs_nxt;
  logic           needs_two_r, needs_two_nxt;
  logic           have_first_r, have_first_nxt;
  logic [6:0]     held_first_r, held_first_nxt;
  logic           in_sysex_r, in_sysex_nxt;
  logic           ovr_r, ovr_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [FW-1:0]  len_r, len_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [15:0]    ovf_cnt_r, ovf_cnt_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic [7:0]     out_status_r, out_status_nxt;
  logic [6:0]     out_first_r, out_first_nxt;
  logic [6:0]     out_second_r, out_second_nxt;
  logic [6:0]     out_sx_r, out_sx_nxt;
  logic [5:0]     out_len_r, out_len_nxt;
  logic           out_last_r, out_last_nxt;
  logic [15:0]    out_ovf_r, out_ovf_nxt;

  logic           slot_free;
  logic           in_fire;
  logic           store_full;
  logic           flush_last;
  logic           ram_wr_en;
  logic [6:0]     ram_rd_data;

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && slot_free;
  assign in_fire    = in_valid && in_ready;
  assign store_full = (fill_r == FW'(msp_pkg::SYSEX_DEPTH));
  assign flush_last = ((FW'(rd_idx_r) + FW'(1)) == len_r);

  // payload store
  msp_ram #(
    .WIDTH (7),
    .DEPTH (msp_pkg::SYSEX_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_rx_byte[6:0]),
    .rd_addr (rd_idx_nxt),
    .rd_data (ram_rd_data)
  );

  // parser next-state logic
  always_comb begin
    state_nxt      = state_r;
    rs_nxt         = rs_r;
    needs_two_nxt  = needs_two_r;
    have_first_nxt = have_first_r;
    held_first_nxt = held_first_r;
    in_sysex_nxt   = in_sysex_r;
    ovr_nxt        = ovr_r;
    fill_nxt       = fill_r;
    len_nxt        = len_r;
    rd_idx_nxt     = rd_idx_r;
    ovf_cnt_nxt    = ovf_cnt_r;
    ram_wr_en      = 1'b0;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_sx_nxt     = out_sx_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;

    case (state_r)
      S_IDLE: begin
        rd_idx_nxt = '0;
        if (in_fire) begin
          if (in_rx_byte[7]) begin
            // status byte
            if (in_rx_byte inside {[msp_pkg::ST_REALTIME_MIN:8'hFF]}) begin
              // real-time: no effect
            end else if (in_sysex_r && in_rx_byte == msp_pkg::ST_SYSEX_END) begin
              if (!ovr_r && fill_r != '0) begin
                len_nxt   = fill_r;
                state_nxt = S_FLUSH;
              end
              in_sysex_nxt = 1'b0;
              ovr_nxt      = 1'b0;
              fill_nxt     = '0;
            end else begin
              in_sysex_nxt = 1'b0;
              ovr_nxt      = 1'b0;
              fill_nxt     = '0;
              if (in_rx_byte == msp_pkg::ST_SYSEX_START) begin
                in_sysex_nxt = 1'b1;
                rs_nxt       = '0;
              end else if (in_rx_byte[7:4] == msp_pkg::ST_SYSTEM) begin
                rs_nxt = '0;
              end else begin
                rs_nxt         = in_rx_byte;
                needs_two_nxt  = !(in_rx_byte[7:4] inside {msp_pkg::ST_PROG_CHANGE,
                                                           msp_pkg::ST_CHAN_PRESS});
                have_first_nxt = 1'b0;
              end
            end
          end else if (in_sysex_r) begin
            // sysex payload byte
            if (store_full) begin
              if (!ovr_r) begin
                ovr_nxt = 1'b1;
                if (ovf_cnt_r != msp_pkg::OVF_MAX) begin
                  ovf_cnt_nxt = ovf_cnt_r + 16'd1;
                end
              end
            end else begin
              ram_wr_en = 1'b1;
              fill_nxt  = fill_r + FW'(1);
            end
          end else if (rs_r != '0) begin
            // channel data with running status
            if (!have_first_r && needs_two_r) begin
              held_first_nxt = in_rx_byte[6:0];
              have_first_nxt = 1'b1;
            end else begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = msp_pkg::KIND_CHANNEL;
              out_status_nxt = rs_r;
              out_first_nxt  = have_first_r ? held_first_r : in_rx_byte[6:0];
              out_second_nxt = have_first_r ? in_rx_byte[6:0] : 7'd0;
              out_sx_nxt     = 7'd0;
              out_len_nxt    = 6'd0;
              out_last_nxt   = 1'b1;
              out_ovf_nxt    = ovf_cnt_r;
              held_first_nxt = in_rx_byte[6:0];
              have_first_nxt = 1'b0;
            end
          end
        end
      end
      S_FLUSH: begin
        // read data for rd_idx_r is valid this cycle
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = msp_pkg::KIND_SYSEX;
          out_status_nxt = 8'd0;
          out_first_nxt  = 7'd0;
          out_second_nxt = 7'd0;
          out_sx_nxt     = ram_rd_data;
          out_len_nxt    = 6'(len_r);
          out_last_nxt   = flush_last;
          out_ovf_nxt    = ovf_cnt_r;
          if (flush_last) begin
            state_nxt  = S_IDLE;
            rd_idx_nxt = '0;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rs_r         <= '0;
      needs_two_r  <= 1'b0;
      have_first_r <= 1'b0;
      held_first_r <= '0;
      in_sysex_r   <= 1'b0;
      ovr_r        <= 1'b0;
      fill_r       <= '0;
      len_r        <= '0;
      rd_idx_r     <= '0;
      ovf_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rs_r         <= rs_nxt;
      needs_two_r  <= needs_two_nxt;
      have_first_r <= have_first_nxt;
      held_first_r <= held_first_nxt;
      in_sysex_r   <= in_sysex_nxt;
      ovr_r        <= ovr_nxt;
      fill_r       <= fill_nxt;
      len_r        <= len_nxt;
      rd_idx_r     <= rd_idx_nxt;
      ovf_cnt_r    <= ovf_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_sx_r     <= out_sx_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_status_byte    = out_status_r;
  assign out_first_data     = out_first_r;
  assign out_second_data    = out_second_r;
  assign out_sysex_data     = out_sx_r;
  assign out_sysex_length   = out_len_r;
  assign out_last_of_run    = out_last_r;
  assign out_overflow_count = out_ovf_r;

endmodule

// ===== rtl/msp_ram.sv =====
// ----------------------------------------------------------------------------
// msp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/msp_checker.sv =====
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks for the MIDI stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_stream_parser_with_sysex_top_macros.svh"

module msp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_status_byte,
  input logic [6:0]  out_first_data,
  input logic [6:0]  out_second_data,
  input logic [6:0]  out_sysex_data,
  input logic [5:0]  out_sysex_length,
  input logic        out_last_of_run,
  input logic [15:0] out_overflow_count
);

  // stalled item holds
  `MSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sysex_data) && $stable(out_status_byte) && $stable(out_first_data) && $stable(out_second_data), "output item changed while stalled")

  // channel item shape
  `MSP_ASSERT_NOW(a_chan_shape, out_valid && out_kind == msp_pkg::KIND_CHANNEL, out_last_of_run && out_status_byte[7] && out_sysex_data == 7'd0 && out_sysex_length == 6'd0, "malformed channel item")

  // sysex run continues back to back with fixed length and count
  `MSP_ASSERT_NEXT(a_run_cont, out_valid && out_ready && out_kind == msp_pkg::KIND_SYSEX && !out_last_of_run, out_valid && out_kind == msp_pkg::KIND_SYSEX && $stable(out_sysex_length) && $stable(out_overflow_count), "sysex run broken")

  // no input taken in the middle of a run
  `MSP_ASSERT_NOW(a_run_block, out_valid && out_kind == msp_pkg::KIND_SYSEX && !out_last_of_run, !in_ready, "input accepted during sysex flush")

endmodule

bind midi_stream_parser_with_sysex_top msp_checker u_msp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_status_byte    (out_status_byte),
  .out_first_data     (out_first_data),
  .out_second_data    (out_second_data),
  .out_sysex_data     (out_sysex_data),
  .out_sysex_length   (out_sysex_length),
  .out_last_of_run    (out_last_of_run),
  .out_overflow_count (out_overflow_count)
);
